>>> rtl/core/stdp_pkg.sv
// Shared types and constants for the STDP weight update block.
package stdp_pkg;

  localparam int TIME_W    = 21;
  localparam int WEIGHT_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int RATE_W    = 20;
  localparam int EXP_W     = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  localparam int DEF_TAU_WINDOW_US       = 1000;
  localparam int DEF_EXP_TABLE_DEPTH     = 256;
  localparam int DEF_EXP_TABLE_SPAN_TAUS = 8;

  localparam logic [GAIN_W-1:0]          RST_GAIN_POT  = 16'd6554;
  localparam logic [GAIN_W-1:0]          RST_GAIN_DEP  = 16'd6881;
  localparam logic signed [WEIGHT_W-1:0] RST_W_REST    = 16'sd4096;
  localparam logic signed [WEIGHT_W-1:0] RST_W_CEILING = 16'sd7373;
  localparam logic signed [WEIGHT_W-1:0] RST_W_FLOOR   = -16'sd2048;
  localparam logic [RATE_W-1:0]          RST_DECAY     = 20'd42950;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_POT  = 3'd0,
    REG_GAIN_DEP  = 3'd1,
    REG_W_REST    = 3'd2,
    REG_W_CEILING = 3'd3,
    REG_W_FLOOR   = 3'd4,
    REG_DECAY     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_CEIL  = 2'd1,
    CLAMP_FLOOR = 2'd2
  } clamp_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_in;
    logic [TIME_W-1:0]          pre_time;
    logic [TIME_W-1:0]          post_time;
  } item_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_out;
    clamp_t                     clamp_status;
  } result_t;

endpackage

>>> rtl/core/stdp_weight_update.sv
// Pipelined pair-based STDP weight update with exponential timing window.
//
// One spike pair per word; while item_stall is low a new word is taken every
// cycle. Each of the nine stages holds a valid bit and loads whenever it is
// empty or the stage after it moves, so a stall on the result side backs up
// only through full stages and empty slots are squeezed out. The window table
// of EXP_TABLE_DEPTH entries is built at elaboration and read as constant
// logic in stage six; the table index comes from a reciprocal multiply with
// a one-step correction, and the decay product is formed as two partial
// products summed in the following stage.
module stdp_weight_update
  import stdp_pkg::*;
#(
  parameter int TAU_WINDOW_US       = DEF_TAU_WINDOW_US,
  parameter int EXP_TABLE_DEPTH     = DEF_EXP_TABLE_DEPTH,
  parameter int EXP_TABLE_SPAN_TAUS = DEF_EXP_TABLE_SPAN_TAUS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result
);

  localparam int NSTAGE      = 9;
  localparam int MAG_W       = TIME_W;
  localparam int DT_W        = TIME_W + 1;
  localparam int DIFF_W      = WEIGHT_W + 1;
  localparam int ADIFF_W     = WEIGHT_W;
  localparam int WIN_SPAN    = EXP_TABLE_SPAN_TAUS * TAU_WINDOW_US;
  localparam int WS_W        = $clog2(WIN_SPAN + 1);
  localparam int WCMP_W      = (MAG_W > WS_W) ? MAG_W + 1 : WS_W + 1;
  localparam int RECIP_SHIFT = TIME_W;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SHIFT) * EXP_TABLE_DEPTH) / WIN_SPAN;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PQ_W        = MAG_W + RECIP_W;
  localparam int IDX_W       = $clog2(EXP_TABLE_DEPTH);
  localparam int IDXC_W      = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int DEPC_W      = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int QD_W        = IDXC_W + 1 + WS_W;
  localparam int MDEP_W      = MAG_W + DEPC_W;
  localparam int ICMP_W      = (QD_W > MDEP_W) ? QD_W : MDEP_W;
  localparam int MD_W        = MAG_W + ADIFF_W;
  localparam int MD_LO_W     = MD_W / 2;
  localparam int MD_HI_W     = MD_W - MD_LO_W;
  localparam int PM_W        = MD_W + RATE_W;
  localparam int PR_W        = PM_W + 1 - 32;
  localparam int DEC_W       = PR_W + 1;
  localparam int GE_W        = GAIN_W + EXP_W + 1;
  localparam int CHG_W       = GE_W - 20;
  localparam int DW_W        = CHG_W + 1;
  localparam int WN_W        = ((DEC_W > DIFF_W) ? DEC_W : DIFF_W) + 2;

  function automatic longint unsigned div_term(input longint unsigned v,
                                               input int unsigned k);
    longint unsigned r;
    case (k)
      1:       r = v;
      2:       r = v / 2;
      3:       r = v / 3;
      4:       r = v / 4;
      5:       r = v / 5;
      6:       r = v / 6;
      7:       r = v / 7;
      8:       r = v / 8;
      9:       r = v / 9;
      10:      r = v / 10;
      11:      r = v / 11;
      12:      r = v / 12;
      13:      r = v / 13;
      14:      r = v / 14;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [EXP_W-1:0] rom_entry(input int unsigned idx);
    longint unsigned num;
    longint unsigned y;
    longint unsigned term;
    longint unsigned s;
    longint          sum;
    num  = longint'(idx) * EXP_TABLE_SPAN_TAUS * (64'd1 << 26);
    y    = (num + EXP_TABLE_DEPTH / 2) / EXP_TABLE_DEPTH;
    term = 64'd1 << 30;
    sum  = longint'(term);
    if (y > (64'd1 << 30)) y = 64'd1 << 30;
    for (int unsigned k = 1; k <= 14; k++) begin
      term = div_term((term * y) >> 30, k);
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    s = longint'(sum);
    if (s > (64'd1 << 30)) s = 64'd1 << 30;
    for (int r = 0; r < 4; r++) begin
      s = (s * s + (64'd1 << 29)) >> 30;
    end
    return EXP_W'((s + (64'd1 << 13)) >> 14);
  endfunction

  logic [EXP_W-1:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_rom
    assign exp_rom[gi] = rom_entry(gi);
  end

  // configuration registers
  logic [GAIN_W-1:0]          gain_potentiate;
  logic [GAIN_W-1:0]          gain_depress;
  logic signed [WEIGHT_W-1:0] weight_rest;
  logic signed [WEIGHT_W-1:0] weight_ceiling;
  logic signed [WEIGHT_W-1:0] weight_floor;
  logic [RATE_W-1:0]          decay_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_potentiate <= RST_GAIN_POT;
      gain_depress    <= RST_GAIN_DEP;
      weight_rest     <= RST_W_REST;
      weight_ceiling  <= RST_W_CEILING;
      weight_floor    <= RST_W_FLOOR;
      decay_rate      <= RST_DECAY;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN_POT:  gain_potentiate <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DEP:  gain_depress    <= cfg_data[GAIN_W-1:0];
        REG_W_REST:    weight_rest     <= signed'(cfg_data[WEIGHT_W-1:0]);
        REG_W_CEILING: weight_ceiling  <= signed'(cfg_data[WEIGHT_W-1:0]);
        REG_W_FLOOR:   weight_floor    <= signed'(cfg_data[WEIGHT_W-1:0]);
        REG_DECAY:     decay_rate      <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage flow control
  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] ena;

  always_comb begin
    ena[NSTAGE] = !vld[NSTAGE] || !result_stall;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      ena[k] = !vld[k] || ena[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ena[1]) vld[1] <= item_valid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (ena[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign item_stall   = !ena[1];
  assign result_valid = vld[NSTAGE];

  // stage 1: time difference and weight offset
  logic signed [DT_W-1:0]     s1_dt;
  logic signed [DIFF_W-1:0]   s1_diff;
  logic signed [WEIGHT_W-1:0] s1_w;

  always_ff @(posedge clk) begin
    if (ena[1]) begin
      s1_dt   <= signed'({1'b0, item.pre_time}) - signed'({1'b0, item.post_time});
      s1_diff <= DIFF_W'(item.weight_in) - DIFF_W'(weight_rest);
      s1_w    <= item.weight_in;
    end
  end

  // stage 2: magnitudes and signs
  logic [MAG_W-1:0]           s2_mag;
  logic [ADIFF_W-1:0]         s2_adiff;
  logic                       s2_pot;
  logic                       s2_neg;
  logic signed [WEIGHT_W-1:0] s2_w;

  always_ff @(posedge clk) begin
    if (ena[2]) begin
      s2_mag   <= MAG_W'(s1_dt[DT_W-1] ? -s1_dt : s1_dt);
      s2_adiff <= ADIFF_W'(s1_diff[DIFF_W-1] ? -s1_diff : s1_diff);
      s2_pot   <= s1_dt[DT_W-1] || (s1_dt == '0);
      s2_neg   <= s1_dt[DT_W-1] ^ s1_diff[DIFF_W-1];
      s2_w     <= s1_w;
    end
  end

  // stage 3: index estimate, window test, first decay product
  logic [PQ_W-1:0]            s3_pq_next;
  logic [IDXC_W-1:0]          s3_q;
  logic [MDEP_W-1:0]          s3_mdep;
  logic                       s3_win;
  logic [MD_W-1:0]            s3_md;
  logic                       s3_pot;
  logic                       s3_neg;
  logic signed [WEIGHT_W-1:0] s3_w;

  assign s3_pq_next = PQ_W'(s2_mag) * PQ_W'(RECIP);

  always_ff @(posedge clk) begin
    if (ena[3]) begin
      s3_q    <= IDXC_W'(s3_pq_next >> RECIP_SHIFT);
      s3_mdep <= MDEP_W'(s2_mag) * MDEP_W'(EXP_TABLE_DEPTH);
      s3_win  <= WCMP_W'(s2_mag) < WCMP_W'(WIN_SPAN);
      s3_md   <= MD_W'(s2_mag) * MD_W'(s2_adiff);
      s3_pot  <= s2_pot;
      s3_neg  <= s2_neg;
      s3_w    <= s2_w;
    end
  end

  // stage 4: correction product, decay partial products
  logic [QD_W-1:0]                s4_qd;
  logic [IDXC_W-1:0]              s4_q;
  logic [MDEP_W-1:0]              s4_mdep;
  logic                           s4_win;
  logic [MD_HI_W+RATE_W-1:0]      s4_phi;
  logic [MD_LO_W+RATE_W-1:0]      s4_plo;
  logic                           s4_pot;
  logic                           s4_neg;
  logic signed [WEIGHT_W-1:0]     s4_w;

  always_ff @(posedge clk) begin
    if (ena[4]) begin
      s4_qd   <= (QD_W'(s3_q) + QD_W'(1)) * QD_W'(WIN_SPAN);
      s4_q    <= s3_q;
      s4_mdep <= s3_mdep;
      s4_win  <= s3_win;
      s4_phi  <= (MD_HI_W + RATE_W)'(s3_md[MD_W-1:MD_LO_W]) *
                 (MD_HI_W + RATE_W)'(decay_rate);
      s4_plo  <= (MD_LO_W + RATE_W)'(s3_md[MD_LO_W-1:0]) *
                 (MD_LO_W + RATE_W)'(decay_rate);
      s4_pot  <= s3_pot;
      s4_neg  <= s3_neg;
      s4_w    <= s3_w;
    end
  end

  // stage 5: final table index, decay sum
  logic [IDXC_W-1:0]          s5_idx_next;
  logic [IDX_W-1:0]           s5_idx;
  logic                       s5_win;
  logic [PM_W-1:0]            s5_pm;
  logic                       s5_pot;
  logic                       s5_neg;
  logic signed [WEIGHT_W-1:0] s5_w;

  assign s5_idx_next = (ICMP_W'(s4_qd) <= ICMP_W'(s4_mdep)) ? s4_q + 1'b1 : s4_q;

  always_ff @(posedge clk) begin
    if (ena[5]) begin
      s5_idx <= s4_win ? IDX_W'(s5_idx_next) : '0;
      s5_win <= s4_win;
      s5_pm  <= (PM_W'(s4_phi) << MD_LO_W) + PM_W'(s4_plo);
      s5_pot <= s4_pot;
      s5_neg <= s4_neg;
      s5_w   <= s4_w;
    end
  end

  // stage 6: table read, decay rounding
  logic [PM_W:0]              s6_rnd_next;
  logic [EXP_W-1:0]           s6_e;
  logic [PR_W-1:0]            s6_pr;
  logic                       s6_pot;
  logic                       s6_neg;
  logic signed [WEIGHT_W-1:0] s6_w;

  assign s6_rnd_next = {1'b0, s5_pm} + (PM_W + 1)'(64'h8000_0000);

  always_ff @(posedge clk) begin
    if (ena[6]) begin
      s6_e   <= s5_win ? exp_rom[s5_idx] : '0;
      s6_pr  <= PR_W'(s6_rnd_next >> 32);
      s6_pot <= s5_pot;
      s6_neg <= s5_neg;
      s6_w   <= s5_w;
    end
  end

  // stage 7: gain scaling, signed decay
  logic [GE_W-1:0]            s7_ge_next;
  logic [CHG_W-1:0]           s7_chg_next;
  logic signed [DW_W-1:0]     s7_dw;
  logic signed [DEC_W-1:0]    s7_decay;
  logic signed [WEIGHT_W-1:0] s7_w;

  assign s7_ge_next  = GE_W'(s6_pot ? gain_potentiate : gain_depress) * GE_W'(s6_e) +
                       GE_W'(32'h0008_0000);
  assign s7_chg_next = CHG_W'(s7_ge_next >> 20);

  always_ff @(posedge clk) begin
    if (ena[7]) begin
      s7_dw    <= s6_pot ? signed'({1'b0, s7_chg_next}) : -signed'({1'b0, s7_chg_next});
      s7_decay <= s6_neg ? -signed'({1'b0, s6_pr}) : signed'({1'b0, s6_pr});
      s7_w     <= s6_w;
    end
  end

  // stage 8: new weight before clamping
  logic signed [WN_W-1:0] s8_wn;

  always_ff @(posedge clk) begin
    if (ena[8]) begin
      s8_wn <= WN_W'(s7_w) + WN_W'(s7_dw) - WN_W'(s7_decay);
    end
  end

  // stage 9: clamp and output register
  always_ff @(posedge clk) begin
    if (ena[9]) begin
      if (s8_wn > WN_W'(weight_ceiling)) begin
        result.weight_out   <= weight_ceiling;
        result.clamp_status <= CLAMP_CEIL;
      end else if (s8_wn < WN_W'(weight_floor)) begin
        result.weight_out   <= weight_floor;
        result.clamp_status <= CLAMP_FLOOR;
      end else begin
        result.weight_out   <= WEIGHT_W'(s8_wn);
        result.clamp_status <= CLAMP_NONE;
      end
    end
  end

endmodule

>>> bench/tb_stdp_weight_update.sv
// Self-checking testbench for the STDP weight update pipeline.
module tb_stdp_weight_update;
  import stdp_pkg::*;

  localparam int N_ROWS      = 24;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 100;
  localparam int IDLE_PCT    = 22;
  localparam int CALM_LO     = 150;
  localparam int CALM_HI     = 300;
  localparam int HOLD_AT     = 480;
  localparam int HOLD_LEN    = 80;
  localparam int SETTLE      = 16;
  localparam int WATCHDOG    = 4000;
  localparam int TIME_MAX    = 2097151;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    item_t   word;
    logic    known;
    result_t want;
  } pair_row_t;

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_DAT_W-1:0] cfg_data     = '0;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  item_t                item         = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;

  logic [GAIN_W-1:0]          gain_pot_cfg;
  logic [GAIN_W-1:0]          gain_dep_cfg;
  logic signed [WEIGHT_W-1:0] rest_cfg;
  logic signed [WEIGHT_W-1:0] ceil_cfg;
  logic signed [WEIGHT_W-1:0] floor_cfg;
  logic [RATE_W-1:0]          decay_cfg;

  logic [EXP_W-1:0] window_rom [DEF_EXP_TABLE_DEPTH];

  result_t weight_due [$];
  result_t want_now;
  int      errors       = 0;
  int      words_sent   = 0;
  int      results_seen = 0;
  int      hold_left    = 0;
  logic    held         = 1'b0;
  int      quiet_cycles = 0;

  pair_row_t pair_rows [N_ROWS] = '{
    '{'{16'sd4096, 21'd0, 21'd0}, 1'b1, '{16'sd4506, CLAMP_NONE}},
    '{'{16'sd32767, 21'd5, 21'd5}, 1'b1, '{16'sd7373, CLAMP_CEIL}},
    '{'{16'sh8000, 21'd2097151, 21'd2097151}, 1'b1, '{-16'sd2048, CLAMP_FLOOR}},
    '{'{16'sd4096, 21'd2097151, 21'd0}, 1'b1, '{16'sd4096, CLAMP_NONE}},
    '{'{16'sd4096, 21'd0, 21'd2097151}, 1'b1, '{16'sd4096, CLAMP_NONE}},
    '{'{16'sd4096, 21'd100, 21'd0}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'sd4096, 21'd0, 21'd100}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'sd4096, 21'd31, 21'd0}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'sd4096, 21'd32, 21'd0}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'sd4096, 21'd7999, 21'd0}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'sd4096, 21'd8000, 21'd0}, 1'b1, '{16'sd4096, CLAMP_NONE}},
    '{'{16'sd4096, 21'd0, 21'd8000}, 1'b1, '{16'sd4096, CLAMP_NONE}},
    '{'{16'sd4096, 21'd0, 21'd7999}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'sd0, 21'd1000, 21'd0}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'sd8192, 21'd0, 21'd1000}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{-16'sd1, 21'd500, 21'd600}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'sd32767, 21'd2097151, 21'd0}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'sh8000, 21'd2097151, 21'd0}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'sh8000, 21'd0, 21'd2097151}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'sd32767, 21'd0, 21'd2097151}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'sh5555, 21'h0AAAAA, 21'h155555}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'shAAAA, 21'h155555, 21'h0AAAAA}, 1'b0, '{16'sd0, CLAMP_NONE}},
    '{'{16'sd6963, 21'd0, 21'd0}, 1'b1, '{16'sd7373, CLAMP_NONE}},
    '{'{-16'sd2458, 21'd0, 21'd0}, 1'b1, '{-16'sd2048, CLAMP_NONE}}
  };

  stdp_weight_update u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [EXP_W-1:0] window_entry(input longint unsigned idx);
    longint unsigned y;
    longint unsigned term;
    longint unsigned s;
    longint          acc;
    y = (idx * DEF_EXP_TABLE_SPAN_TAUS * (64'd1 << 26) + DEF_EXP_TABLE_DEPTH / 2) /
        DEF_EXP_TABLE_DEPTH;
    if (y > ONE_Q30) y = ONE_Q30;
    term = ONE_Q30;
    acc  = longint'(ONE_Q30);
    for (int k = 1; k <= 14; k++) begin
      term = ((term * y) >> 30) / longint'(k);
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    s = acc;
    if (s > ONE_Q30) s = ONE_Q30;
    repeat (4) s = (s * s + (64'd1 << 29)) >> 30;
    s = (s + (64'd1 << 13)) >> 14;
    return s[EXP_W-1:0];
  endfunction

  function automatic result_t next_weight(input item_t w);
    longint          wt;
    longint          dt;
    longint          diff;
    longint          dw;
    longint          decay;
    longint          wn;
    longint unsigned mag;
    longint unsigned idx;
    longint unsigned e;
    longint unsigned chg;
    longint unsigned adiff;
    longint unsigned pmag;
    logic            neg;
    result_t         r;
    wt   = longint'($signed(w.weight_in));
    dt   = longint'(w.pre_time) - longint'(w.post_time);
    mag  = (dt < 0) ? -dt : dt;
    idx  = (mag * DEF_EXP_TABLE_DEPTH) / (DEF_EXP_TABLE_SPAN_TAUS * DEF_TAU_WINDOW_US);
    e    = (idx < DEF_EXP_TABLE_DEPTH) ? longint'(window_rom[idx]) : 0;
    if (dt <= 0) begin
      chg = (longint'(gain_pot_cfg) * e + (64'd1 << 19)) >> 20;
      dw  = longint'(chg);
    end else begin
      chg = (longint'(gain_dep_cfg) * e + (64'd1 << 19)) >> 20;
      dw  = -longint'(chg);
    end
    diff  = wt - longint'(rest_cfg);
    neg   = ((dt < 0) != (diff < 0)) && dt != 0 && diff != 0;
    adiff = (diff < 0) ? -diff : diff;
    pmag  = mag * adiff * longint'(decay_cfg);
    pmag  = (pmag + (64'd1 << 31)) >> 32;
    decay = neg ? -longint'(pmag) : longint'(pmag);
    wn    = wt + dw - decay;
    r.clamp_status = CLAMP_NONE;
    if (wn > longint'(ceil_cfg)) begin
      wn = longint'(ceil_cfg);
      r.clamp_status = CLAMP_CEIL;
    end else if (wn < longint'(floor_cfg)) begin
      wn = longint'(floor_cfg);
      r.clamp_status = CLAMP_FLOOR;
    end
    r.weight_out = wn[WEIGHT_W-1:0];
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_GAIN_POT:  gain_pot_cfg = val[GAIN_W-1:0];
      REG_GAIN_DEP:  gain_dep_cfg = val[GAIN_W-1:0];
      REG_W_REST:    rest_cfg     = val[WEIGHT_W-1:0];
      REG_W_CEILING: ceil_cfg     = val[WEIGHT_W-1:0];
      REG_W_FLOOR:   floor_cfg    = val[WEIGHT_W-1:0];
      REG_DECAY:     decay_cfg    = val[RATE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_phase(input int p);
    logic [15:0]       gp;
    logic [15:0]       gd;
    logic [15:0]       wr;
    logic [15:0]       wc;
    logic [15:0]       wf;
    logic [RATE_W-1:0] dr;
    case (p)
      1: begin
        gp = 16'hFFFF; gd = 16'hFFFF; wr = 16'h7FFF;
        wc = 16'h7FFF; wf = 16'h8000; dr = 20'hFFFFF;
      end
      2: begin
        gp = 16'h0000; gd = 16'h0000; wr = 16'h8000;
        wc = 16'h8000; wf = 16'h7FFF; dr = 20'h00000;
      end
      3: begin
        gp = 16'($urandom); gd = 16'($urandom); wr = 16'($urandom);
        wc = 16'd0; wf = 16'd1000; dr = 20'($urandom_range(100000, 0));
      end
      default: begin
        gp = 16'($urandom); gd = 16'($urandom); wr = 16'($urandom);
        wc = 16'($urandom_range(32767, 2048));
        wf = 16'(-int'($urandom_range(32768, 0)));
        dr = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(100000, 0));
      end
    endcase
    write_reg(REG_GAIN_POT,  {4'($urandom), gp});
    write_reg(REG_GAIN_DEP,  {4'($urandom), gd});
    write_reg(REG_W_REST,    {4'($urandom), wr});
    write_reg(REG_W_CEILING, {4'($urandom), wc});
    write_reg(REG_W_FLOOR,   {4'($urandom), wf});
    write_reg(REG_DECAY,     dr);
    write_reg(REG_SPARE_A,   20'($urandom));
    write_reg(REG_SPARE_B,   20'($urandom));
    cfg_write <= 1'b0;
  endtask

  task automatic offer(input item_t w, input logic known, input result_t want);
    while (!(words_sent >= CALM_LO && words_sent < CALM_HI) &&
           $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    weight_due.push_back(known ? want : next_weight(w));
    words_sent++;
  endtask

  task automatic run_phase(input int n);
    item_t w;
    int    pre;
    int    post;
    int    off;
    for (int i = 0; i < n; i++) begin
      w.weight_in = 16'($urandom);
      post = $urandom_range(TIME_MAX, 0);
      case ($urandom_range(9))
        0: pre = $urandom_range(TIME_MAX, 0);
        1: pre = post;
        default: begin
          off = int'($urandom_range(18000, 0)) - 9000;
          pre = post + off;
          if (pre < 0 || pre > TIME_MAX) pre = post - off;
        end
      endcase
      w.pre_time  = 21'(pre);
      w.post_time = 21'(post);
      offer(w, 1'b0, '0);
    end
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (weight_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // check results in order; take one long hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (result_valid && !result_stall) begin
      results_seen++;
      if (weight_due.size() == 0) begin
        $display("%0t: unexpected word weight_out %0d clamp %0d", $time,
                 $signed(result.weight_out), result.clamp_status);
        errors++;
      end else begin
        want_now = weight_due.pop_front();
        if (result.weight_out !== want_now.weight_out) begin
          $display("%0t: weight_out expected %0d got %0d", $time,
                   $signed(want_now.weight_out), $signed(result.weight_out));
          errors++;
        end
        if (result.clamp_status !== want_now.clamp_status) begin
          $display("%0t: clamp_status expected %0d got %0d", $time,
                   want_now.clamp_status, result.clamp_status);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (!held && results_seen >= HOLD_AT && item_valid) begin
      held         <= 1'b1;
      hold_left    <= HOLD_LEN;
      result_stall <= 1'b1;
    end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    gain_pot_cfg = RST_GAIN_POT;
    gain_dep_cfg = RST_GAIN_DEP;
    rest_cfg     = RST_W_REST;
    ceil_cfg     = RST_W_CEILING;
    floor_cfg    = RST_W_FLOOR;
    decay_cfg    = RST_DECAY;
    for (int i = 0; i < DEF_EXP_TABLE_DEPTH; i++) window_rom[i] = window_entry(i);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_ROWS; i++) offer(pair_rows[i].word, pair_rows[i].known, pair_rows[i].want);
    run_phase(PHASE_WORDS);
    for (int p = 1; p < PHASES; p++) begin
      settle();
      program_phase(p);
      run_phase(PHASE_WORDS);
    end
    settle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
